[rtl/vagdec_pkg.sv]
`default_nettype none

package vagdec_pkg;

    // line layout
    localparam int SAMPLES_PER_LINE = 28;
    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
    localparam logic [POS_W-1:0] POS_FLAG   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(1 + SAMPLES_PER_LINE / 2);

    localparam logic [7:0] SILENT_FLAG = 8'h07;
    localparam logic [2:0] FILTER_MAX  = 3'd4;

    // history format
    localparam int FRACTION_BITS_DEF = 16;
    localparam int HIST_W = 40;
    localparam int COEF_W = 8;
    localparam int SAMPLE_W = 16;

    typedef struct packed {
        logic       channel;
        logic [7:0] line_byte;
    } dec_line_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       line_end;
    } dec_sample_t;

    // filter taps in 64ths, newest history
    function automatic logic signed [COEF_W-1:0] coef_new(input logic [2:0] filter);
        logic signed [COEF_W-1:0] c;
        unique case (filter)
            3'd0:    c = COEF_W'(0);
            3'd1:    c = COEF_W'(60);
            3'd2:    c = COEF_W'(115);
            3'd3:    c = COEF_W'(98);
            3'd4:    c = COEF_W'(122);
            default: c = COEF_W'(0);
        endcase
        return c;
    endfunction

    // filter taps in 64ths, older history
    function automatic logic signed [COEF_W-1:0] coef_old(input logic [2:0] filter);
        logic signed [COEF_W-1:0] c;
        unique case (filter)
            3'd0:    c = COEF_W'(0);
            3'd1:    c = COEF_W'(0);
            3'd2:    c = -COEF_W'(52);
            3'd3:    c = -COEF_W'(55);
            3'd4:    c = -COEF_W'(60);
            default: c = COEF_W'(0);
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/adpcm_vag_line_decoder_top.sv]
`default_nettype none

// vag adpcm line decoder
// input channel (line_valid / line_stall / line_data): one byte of a 16-byte
//   adpcm line per word, tagged with the channel whose filter history it uses;
//   byte 0 is the header (filter, shift), byte 1 the flag, bytes 2..15 data
// output channel (sample_valid / sample_stall / sample_data): one 16-bit pcm
//   sample per word, line_end set on the 28th sample of a line
// a data byte is parked in the work register; its low-nibble sample and then
//   its high-nibble sample each pass through the output register
// header and flag bytes are not parked; a data byte stays parked for both
//   nibbles, since the single sample unit runs once per nibble and the second
//   nibble needs the history written by the first
// the output register lets the next byte be taken while a sample waits;
//   while sample_stall keeps a sample waiting, the sample unit holds and
//   line_stall rises once a byte is parked in the work register
// reset clears the byte position, header fields and both channels' history,
//   so the first byte after reset is taken as a header
module adpcm_vag_line_decoder_top
#(
    parameter int FRACTION_BITS = vagdec_pkg::FRACTION_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    line_valid,
    output logic                    line_stall,
    input  vagdec_pkg::dec_line_t   line_data,
    output logic                    sample_valid,
    input  logic                    sample_stall,
    output vagdec_pkg::dec_sample_t sample_data
);
    import vagdec_pkg::*;

    // widths of the filter sum: products of history and taps, plus the
    // scaled nibble term, with headroom for the sum and rounding bias
    localparam int PROD_W = HIST_W + COEF_W;
    localparam int BASE_W = SAMPLE_W;
    localparam int TERM_W = BASE_W + FRACTION_BITS + 6;
    localparam int ACC_W  = ((TERM_W > PROD_W) ? TERM_W : PROD_W) + 2;
    localparam int RND_W  = ACC_W - 6;
    localparam int OUT_W  = HIST_W + 1;
    localparam int HALF   = 1 << (FRACTION_BITS - 1);

    // one data byte in flight, with the header fields of its line
    typedef struct packed {
        logic       channel;
        logic [7:0] data;
        logic [2:0] filter;
        logic [3:0] shift;
        logic       silent;
        logic       last;
    } work_t;

    logic [POS_W-1:0] pos_reg;
    logic [2:0]       filter_reg;
    logic [3:0]       shift_reg;
    logic             silent_reg;

    logic             work_valid_reg;
    logic             nib_sel_reg;
    work_t            work_reg;

    logic signed [HIST_W-1:0] prev_reg  [2];
    logic signed [HIST_W-1:0] older_reg [2];

    logic             sample_valid_reg;
    dec_sample_t      sample_reg;

    // handshake control
    logic out_free;
    logic step;
    logic work_done;
    logic line_fire;
    logic is_data;

    assign out_free  = !sample_valid_reg || !sample_stall;
    assign step      = work_valid_reg && out_free;
    assign work_done = step && nib_sel_reg;
    // a new byte may enter in the cycle the parked one issues its last sample
    assign line_stall = work_valid_reg && !work_done;
    assign line_fire  = line_valid && !line_stall;
    assign is_data    = (pos_reg != POS_HEADER) && (pos_reg != POS_FLAG);

    // sample unit: nibble term plus two-tap filter of the channel history
    logic [3:0]               nibble;
    logic signed [BASE_W-1:0] nib_ext;
    logic signed [BASE_W-1:0] base;
    logic signed [HIST_W-1:0] hist_prev;
    logic signed [HIST_W-1:0] hist_older;
    logic signed [PROD_W-1:0] prod_new;
    logic signed [PROD_W-1:0] prod_old;
    logic signed [ACC_W-1:0]  base_term;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_bias;
    logic signed [RND_W-1:0]  acc_rnd;
    logic                     hist_ovf;
    logic signed [HIST_W-1:0] hist_next;
    logic signed [OUT_W-1:0]  hist_bias;
    logic signed [OUT_W-1:0]  out_rnd;
    logic                     out_ovf;
    logic signed [SAMPLE_W-1:0] pcm;
    dec_sample_t              sample_next;

    assign nibble     = nib_sel_reg ? work_reg.data[7:4] : work_reg.data[3:0];
    // nibble sits in bits 15..12, so the word reads as the signed nibble * 4096
    assign nib_ext    = {nibble, 12'h000};
    assign base       = nib_ext >>> work_reg.shift;
    assign hist_prev  = prev_reg[work_reg.channel];
    assign hist_older = older_reg[work_reg.channel];

    assign prod_new  = PROD_W'(hist_prev) * PROD_W'(coef_new(work_reg.filter));
    assign prod_old  = PROD_W'(hist_older) * PROD_W'(coef_old(work_reg.filter));
    assign base_term = ACC_W'(base) <<< (FRACTION_BITS + 6);
    assign acc       = base_term + ACC_W'(prod_new) + ACC_W'(prod_old);

    // drop the six tap bits, half away from zero
    assign acc_bias = acc + (acc[ACC_W-1] ? ACC_W'(31) : ACC_W'(32));
    assign acc_rnd  = RND_W'(acc_bias >>> 6);

    // saturate to the history width
    assign hist_ovf  = (|acc_rnd[RND_W-1:HIST_W-1]) && !(&acc_rnd[RND_W-1:HIST_W-1]);
    assign hist_next = hist_ovf ? {acc_rnd[RND_W-1], {(HIST_W-1){~acc_rnd[RND_W-1]}}}
                                : acc_rnd[HIST_W-1:0];

    // integer part, half away from zero, then clamp to 16 bits
    assign hist_bias = OUT_W'(hist_next)
                     + (hist_next[HIST_W-1] ? OUT_W'(HALF - 1) : OUT_W'(HALF));
    assign out_rnd   = hist_bias >>> FRACTION_BITS;
    assign out_ovf   = (|out_rnd[OUT_W-1:SAMPLE_W-1]) && !(&out_rnd[OUT_W-1:SAMPLE_W-1]);
    assign pcm       = out_ovf ? {out_rnd[OUT_W-1], {(SAMPLE_W-1){~out_rnd[OUT_W-1]}}}
                               : out_rnd[SAMPLE_W-1:0];

    assign sample_next.sample   = work_reg.silent ? '0 : pcm;
    assign sample_next.line_end = work_reg.last && nib_sel_reg;

    // byte position and header fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            filter_reg <= '0;
            shift_reg  <= '0;
            silent_reg <= 1'b0;
        end
        else if (line_fire)
        begin
            pos_reg <= POS_W'(pos_reg + POS_W'(1));
            if (pos_reg == POS_HEADER)
            begin
                filter_reg <= (line_data.line_byte[7:4] > {1'b0, FILTER_MAX})
                              ? FILTER_MAX : line_data.line_byte[6:4];
                shift_reg  <= line_data.line_byte[3:0];
            end
            if (pos_reg == POS_FLAG)
            begin
                silent_reg <= (line_data.line_byte == SILENT_FLAG);
            end
        end
    end

    // work register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            nib_sel_reg    <= 1'b0;
        end
        else if (line_fire && is_data)
        begin
            work_valid_reg <= 1'b1;
            nib_sel_reg    <= 1'b0;
        end
        else if (work_done)
        begin
            work_valid_reg <= 1'b0;
            nib_sel_reg    <= 1'b0;
        end
        else if (step)
        begin
            nib_sel_reg <= 1'b1;
        end
    end

    // work register payload
    always_ff @(posedge clk)
    begin
        if (line_fire && is_data)
        begin
            work_reg.channel <= line_data.channel;
            work_reg.data    <= line_data.line_byte;
            work_reg.filter  <= filter_reg;
            work_reg.shift   <= shift_reg;
            work_reg.silent  <= silent_reg;
            work_reg.last    <= (pos_reg == POS_LAST);
        end
    end

    // per-channel filter history; a silent line leaves it alone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg[0]  <= '0;
            prev_reg[1]  <= '0;
            older_reg[0] <= '0;
            older_reg[1] <= '0;
        end
        else if (step && !work_reg.silent)
        begin
            prev_reg[work_reg.channel]  <= hist_next;
            older_reg[work_reg.channel] <= hist_prev;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            sample_valid_reg <= 1'b1;
        end
        else if (!sample_stall)
        begin
            sample_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample_valid = sample_valid_reg;
    assign sample_data  = sample_reg;

    // a data byte lands in the work register on its low nibble
    a_data_load: assert property (@(posedge clk) disable iff (!rst_n)
        line_fire && is_data |=> work_valid_reg && !nib_sel_reg)
        else $error("data byte not loaded for its low nibble");

    // the high nibble always follows the low one
    a_second_nibble: assert property (@(posedge clk) disable iff (!rst_n)
        step && !nib_sel_reg |=> work_valid_reg && nib_sel_reg)
        else $error("byte retired after one sample");

    // a silent line gives zero samples
    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        step && work_reg.silent |=> sample_valid && sample_data.sample == '0)
        else $error("silent line gave a nonzero sample");

    // and keeps the history
    a_silent_hist: assert property (@(posedge clk) disable iff (!rst_n)
        step && work_reg.silent |=> $stable(prev_reg[0]) && $stable(prev_reg[1])
                                    && $stable(older_reg[0]) && $stable(older_reg[1]))
        else $error("silent line changed the history");

endmodule

`default_nettype wire
